/* src/pulse_counter_display_driver_unit_macros.svh */
// Assertion macros used by the checker file of the pulse counter display driver.
`ifndef PULSE_COUNTER_DISPLAY_DRIVER_UNIT_MACROS_SVH
`define PULSE_COUNTER_DISPLAY_DRIVER_UNIT_MACROS_SVH

// Property checked on every rising edge of aclk while the block is out of reset.
`define PCDD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property checked on every rising edge of aclk, reset cycles included.
`define PCDD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* src/pcdd_pkg.sv */
// Package with the types, codes and constants of the pulse counter display driver.
package pcdd_pkg;

    // Default parameter values.
    localparam int COUNT_WIDTH_DEF = 20;
    localparam int BURST_LIMIT_DEF = 5;

    // Fixed field widths.
    localparam int OP_W        = 2;
    localparam int FIELD_W     = 20;
    localparam int DELTA_W     = 21;
    localparam int TIME_W      = 16;
    localparam int PULSE_CNT_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    // Register reset values.
    localparam logic [TIME_W-1:0] PULSE_MS_RST      = 16'd10;
    localparam logic [TIME_W-1:0] RESET_HOLD_MS_RST = 16'd100;
    localparam logic [TIME_W-1:0] POST_RESET_MS_RST = 16'd1000;
    localparam logic              HAS_DEC_RST       = 1'b1;

    // Operation codes of an input item.
    typedef enum logic [OP_W-1:0] {
        OP_TICK = 2'd0,
        OP_SET  = 2'd1,
        OP_ADD  = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PULSE_MS      = 2'd0,
        CFG_RESET_HOLD_MS = 2'd1,
        CFG_POST_RESET_MS = 2'd2,
        CFG_HAS_DECREMENT = 2'd3
    } cfg_index_t;

    // Sequencer phases.
    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_RST_PRE  = 3'd1,
        PH_RST_HIGH = 3'd2,
        PH_RST_POST = 3'd3,
        PH_P_HIGH   = 3'd4,
        PH_P_LOW    = 3'd5
    } phase_t;

    // Configuration register contents.
    typedef struct packed {
        logic [TIME_W-1:0] pulse_ms;
        logic [TIME_W-1:0] reset_hold_ms;
        logic [TIME_W-1:0] post_reset_ms;
        logic              has_decrement;
    } cfg_t;

    // Outcome of the reset-or-burst choice.
    typedef struct packed {
        logic                   active;
        logic                   use_reset;
        logic                   going_down;
        logic [PULSE_CNT_W-1:0] pulses;
    } decision_t;

    // Input item, last field in the lowest bits.
    typedef struct packed {
        logic [DELTA_W-1:0] delta;
        logic [FIELD_W-1:0] new_target;
        op_t                operation;
    } item_t;

    // Result item, last field in the lowest bits.
    typedef struct packed {
        logic               busy_res;
        logic [FIELD_W-1:0] goal_count;
        logic [FIELD_W-1:0] shown_count;
        logic               reset_line;
        logic               dec_line;
        logic               inc_line;
    } result_t;

    localparam int ITEM_W   = $bits(item_t);
    localparam int RESULT_W = $bits(result_t);

endpackage

/* src/pcdd_cfg_regs.sv */
// Configuration registers of the pulse counter display driver.
module pcdd_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [pcdd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pcdd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output pcdd_pkg::cfg_t                   cfg
);

    pcdd_pkg::cfg_t cfg_reg;
    pcdd_pkg::cfg_t cfg_next;

    // Timing registers keep their old value on a write of zero.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (pcdd_pkg::cfg_index_t'(cfg_index))
                pcdd_pkg::CFG_PULSE_MS: begin
                    if (cfg_wdata != '0) cfg_next.pulse_ms = cfg_wdata;
                end
                pcdd_pkg::CFG_RESET_HOLD_MS: begin
                    if (cfg_wdata != '0) cfg_next.reset_hold_ms = cfg_wdata;
                end
                pcdd_pkg::CFG_POST_RESET_MS: begin
                    if (cfg_wdata != '0) cfg_next.post_reset_ms = cfg_wdata;
                end
                pcdd_pkg::CFG_HAS_DECREMENT: begin
                    cfg_next.has_decrement = cfg_wdata[0];
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pulse_ms      <= pcdd_pkg::PULSE_MS_RST;
            cfg_reg.reset_hold_ms <= pcdd_pkg::RESET_HOLD_MS_RST;
            cfg_reg.post_reset_ms <= pcdd_pkg::POST_RESET_MS_RST;
            cfg_reg.has_decrement <= pcdd_pkg::HAS_DEC_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/pcdd_decide.sv */
// Choice between a reset sequence and a pulse burst for the driver.
module pcdd_decide #(
    parameter int COUNT_WIDTH = pcdd_pkg::COUNT_WIDTH_DEF,
    parameter int BURST_LIMIT = pcdd_pkg::BURST_LIMIT_DEF
) (
    input  logic [COUNT_WIDTH-1:0] goal,
    input  logic [COUNT_WIDTH-1:0] shown,
    input  pcdd_pkg::cfg_t         cfg,
    output pcdd_pkg::decision_t    decision,
    output logic [COUNT_WIDTH-1:0] landing
);

    localparam int CW = COUNT_WIDTH;
    localparam int PW = pcdd_pkg::PULSE_CNT_W;

    logic          down;
    logic [CW-1:0] span;
    logic [CW+1:0] excess;
    logic          excess_pos;
    logic [CW+15:0] prod;
    logic [17:0]   thresh;
    logic          far;
    logic [PW-1:0] pulses;

    // Distance and direction to the target.
    assign down = goal < shown;
    assign span = down ? (shown - goal) : (goal - shown);

    // The reset pays off when 2*pulse*(distance - goal) exceeds 2*hold + post.
    // Going up, distance - goal is never positive, so only a descent qualifies;
    // there distance - goal equals shown - 2*goal.
    assign excess     = {2'b00, shown} - {1'b0, goal, 1'b0};
    assign excess_pos = !excess[CW+1] && (excess != '0);
    assign prod       = (CW+16)'(excess[CW-1:0]) * (CW+16)'(cfg.pulse_ms);
    assign thresh     = {1'b0, cfg.reset_hold_ms, 1'b0} + {2'b00, cfg.post_reset_ms};
    assign far        = {prod, 1'b0} > (CW+17)'(thresh);

    // Burst length and the count reached once the burst is over.
    assign pulses  = (span > CW'(BURST_LIMIT)) ? PW'(BURST_LIMIT) : span[PW-1:0];
    assign landing = down ? (shown - CW'(pulses)) : (shown + CW'(pulses));

    assign decision.active     = goal != shown;
    assign decision.use_reset  = down && ((excess_pos && far) || !cfg.has_decrement);
    assign decision.going_down = down;
    assign decision.pulses     = pulses;

endmodule

/* src/pcdd_core.sv */
// Target tracking and pulse sequencer of the pulse counter display driver.
module pcdd_core #(
    parameter int COUNT_WIDTH = pcdd_pkg::COUNT_WIDTH_DEF,
    parameter int BURST_LIMIT = pcdd_pkg::BURST_LIMIT_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  pcdd_pkg::item_t     item,
    input  pcdd_pkg::cfg_t      cfg,
    output pcdd_pkg::result_t   result
);

    localparam int CW = COUNT_WIDTH;
    localparam int PW = pcdd_pkg::PULSE_CNT_W;
    localparam int TW = pcdd_pkg::TIME_W;
    localparam int FW = pcdd_pkg::FIELD_W;
    localparam int DW = pcdd_pkg::DELTA_W;
    localparam int SW = CW + DW + 1;

    logic [CW-1:0]     goal_reg, goal_next;
    logic [CW-1:0]     shown_reg, shown_next;
    logic [CW-1:0]     landing_reg, landing_next;
    pcdd_pkg::phase_t  phase_reg, phase_next;
    logic [TW-1:0]     time_left_reg, time_left_next;
    logic [PW-1:0]     pulses_left_reg, pulses_left_next;
    logic              going_down_reg, going_down_next;

    logic [CW-1:0]        decide_shown;
    pcdd_pkg::decision_t  decision;
    logic [CW-1:0]        landing;
    logic                 do_decide;
    logic [TW-1:0]        tl_dec;
    logic [PW-1:0]        pl_dec;
    logic [CW+FW-1:0]     target_wide;
    logic [CW-1:0]        set_goal;
    logic [SW-1:0]        sum;
    logic [CW-1:0]        add_goal;
    logic [CW+FW-1:0]     shown_wide;
    logic [CW+FW-1:0]     goal_wide;

    // At the end of a burst the choice is made on the count the burst reaches.
    assign decide_shown = (phase_reg == pcdd_pkg::PH_P_LOW) ? landing_reg : shown_reg;

    pcdd_decide #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .BURST_LIMIT (BURST_LIMIT)
    ) u_decide (
        .goal     (goal_reg),
        .shown    (decide_shown),
        .cfg      (cfg),
        .decision (decision),
        .landing  (landing)
    );

    // New target for a set item, fitted to the count width.
    assign target_wide = {{CW{1'b0}}, item.new_target};
    assign set_goal    = target_wide[CW-1:0];

    // Target plus signed delta, clamped to the count range.
    assign sum = {{(SW-CW){1'b0}}, goal_reg} + {{(SW-DW){item.delta[DW-1]}}, item.delta};
    always_comb begin
        if (sum[SW-1]) begin
            add_goal = '0;
        end else if (sum > {{(SW-CW){1'b0}}, {CW{1'b1}}}) begin
            add_goal = '1;
        end else begin
            add_goal = sum[CW-1:0];
        end
    end

    // Next state of the sequencer and of the counts.
    always_comb begin
        goal_next        = goal_reg;
        shown_next       = shown_reg;
        landing_next     = landing_reg;
        phase_next       = phase_reg;
        time_left_next   = time_left_reg;
        pulses_left_next = pulses_left_reg;
        going_down_next  = going_down_reg;
        do_decide        = 1'b0;
        tl_dec           = (time_left_reg != '0) ? (time_left_reg - TW'(1)) : '0;
        pl_dec           = (pulses_left_reg != '0) ? (pulses_left_reg - PW'(1)) : '0;

        if (step_en) begin
            unique case (item.operation)
                pcdd_pkg::OP_TICK: begin
                    if (phase_reg == pcdd_pkg::PH_IDLE) begin
                        do_decide = 1'b1;
                    end else begin
                        time_left_next = tl_dec;
                        if (tl_dec == '0) begin
                            unique case (phase_reg)
                                pcdd_pkg::PH_RST_PRE: begin
                                    phase_next     = pcdd_pkg::PH_RST_HIGH;
                                    time_left_next = cfg.reset_hold_ms;
                                end
                                pcdd_pkg::PH_RST_HIGH: begin
                                    phase_next     = pcdd_pkg::PH_RST_POST;
                                    time_left_next = cfg.post_reset_ms;
                                end
                                pcdd_pkg::PH_P_HIGH: begin
                                    phase_next     = pcdd_pkg::PH_P_LOW;
                                    time_left_next = cfg.pulse_ms;
                                end
                                pcdd_pkg::PH_P_LOW: begin
                                    pulses_left_next = pl_dec;
                                    if (pl_dec != '0) begin
                                        phase_next     = pcdd_pkg::PH_P_HIGH;
                                        time_left_next = cfg.pulse_ms;
                                    end else begin
                                        shown_next = landing_reg;
                                        do_decide  = 1'b1;
                                    end
                                end
                                default: begin
                                    do_decide = 1'b1;
                                end
                            endcase
                        end
                    end
                end
                pcdd_pkg::OP_SET: begin
                    goal_next = set_goal;
                end
                pcdd_pkg::OP_ADD: begin
                    goal_next = add_goal;
                end
                pcdd_pkg::OP_NOP: begin
                end
            endcase
        end

        // Start the next sequence, or go idle when the count is on target.
        if (do_decide) begin
            phase_next = pcdd_pkg::PH_IDLE;
            if (decision.active) begin
                if (decision.use_reset) begin
                    shown_next     = '0;
                    phase_next     = pcdd_pkg::PH_RST_PRE;
                    time_left_next = cfg.reset_hold_ms;
                end else begin
                    going_down_next  = decision.going_down;
                    pulses_left_next = decision.pulses;
                    landing_next     = landing;
                    phase_next       = pcdd_pkg::PH_P_HIGH;
                    time_left_next   = cfg.pulse_ms;
                end
            end
        end
    end

    // Result fields reflect the state after this item.
    assign shown_wide = {{FW{1'b0}}, shown_next};
    assign goal_wide  = {{FW{1'b0}}, goal_next};

    always_comb begin
        result.inc_line    = (phase_next == pcdd_pkg::PH_P_HIGH) && !going_down_next;
        result.dec_line    = (phase_next == pcdd_pkg::PH_P_HIGH) && going_down_next;
        result.reset_line  = phase_next == pcdd_pkg::PH_RST_HIGH;
        result.shown_count = shown_wide[FW-1:0];
        result.goal_count  = goal_wide[FW-1:0];
        result.busy_res    = phase_next != pcdd_pkg::PH_IDLE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            goal_reg        <= '0;
            shown_reg       <= '0;
            landing_reg     <= '0;
            phase_reg       <= pcdd_pkg::PH_IDLE;
            time_left_reg   <= '0;
            pulses_left_reg <= '0;
            going_down_reg  <= 1'b0;
        end else begin
            goal_reg        <= goal_next;
            shown_reg       <= shown_next;
            landing_reg     <= landing_next;
            phase_reg       <= phase_next;
            time_left_reg   <= time_left_next;
            pulses_left_reg <= pulses_left_next;
            going_down_reg  <= going_down_next;
        end
    end

endmodule

/* src/pulse_counter_display_driver_unit.sv */
// Pulse counter display driver: stream wrapper around the target sequencer.
//
// The block steers an external counter through increment, decrement and
// reset lines so that its count follows a target. Each transfer on the
// s_ channel carries one item: a millisecond tick, a set-target or an
// add-delta. Each item yields exactly one transfer on the m_ channel with
// the line levels for the coming millisecond, both counts and a busy flag.
// Configuration is written through cfg_wr_en, cfg_index and cfg_wdata; the
// user must write it while no item is in flight, the block does not enforce
// this. A write of zero to a timing register is dropped. An accepted item is
// held in the input register and its result is captured in the result register.
// The input register and the result register let one item enter every
// cycle while m_tready stays high; the decision path is combinational
// (one count-by-16-bit multiply and a compare).
// When the receiver holds m_tready low, the result register stays loaded,
// and once the input register fills s_tready drops until the result is taken.
// Reset (aresetn low at a rising edge) empties both registers, clears the
// counts and the sequencer, and restores the register defaults.
module pulse_counter_display_driver_unit #(
    parameter int COUNT_WIDTH = pcdd_pkg::COUNT_WIDTH_DEF,
    parameter int BURST_LIMIT = pcdd_pkg::BURST_LIMIT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Fields from bit 0: operation[1:0], new_target[21:2], delta[42:22].
    input  logic [pcdd_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // Fields from bit 0: inc_line[0], dec_line[1], reset_line[2],
    // shown_count[22:3], goal_count[42:23], busy_res[43].
    output logic [pcdd_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_wr_en,
    input  logic [pcdd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [pcdd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    pcdd_pkg::cfg_t    cfg;
    pcdd_pkg::item_t   in_item_reg;
    logic              in_valid_reg, in_valid_next;
    pcdd_pkg::result_t out_data_reg;
    logic              out_valid_reg, out_valid_next;
    pcdd_pkg::result_t result;
    logic              advance;
    logic              in_xfer;
    logic              step_en;

    pcdd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Handshake: the result register moves when empty or being taken.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign in_xfer  = s_tvalid && s_tready;
    assign step_en  = in_valid_reg && advance;

    pcdd_core #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .BURST_LIMIT (BURST_LIMIT)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Valid flags of the input and result registers.
    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (in_xfer) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        if (advance) begin
            out_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            in_item_reg <= pcdd_pkg::item_t'(s_tdata[pcdd_pkg::ITEM_W-1:0]);
        end
        if (step_en) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(pcdd_pkg::OUT_TDATA_W - pcdd_pkg::RESULT_W){1'b0}}, out_data_reg};

endmodule

/* src/pcdd_checker.sv */
// Port-level checker of the pulse counter display driver, bound to the top level.
`include "pulse_counter_display_driver_unit_macros.svh"

module pcdd_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [pcdd_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                             m_tvalid,
    input logic                             m_tready
);

    // No result is offered in the cycle after a reset edge.
    `PCDD_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result offered after reset")

    // A stalled result holds its data.
    `PCDD_ASSERT(a_stall_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

    // The increment and decrement lines are never high together.
    `PCDD_ASSERT(a_lines_excl, m_tvalid |-> !(m_tdata[0] && m_tdata[1]), "inc and dec both high")

    // Any active line implies a running sequence.
    `PCDD_ASSERT(a_line_busy, m_tvalid && (m_tdata[0] || m_tdata[1] || m_tdata[2]) |-> m_tdata[43], "line active while idle")

    // With the result register empty the input side always takes a transfer.
    `PCDD_ASSERT(a_ready_empty, !m_tvalid |-> s_tready, "input stalled with empty output")

endmodule

bind pulse_counter_display_driver_unit pcdd_checker u_pcdd_checker (.*);

/* sim/testbench.sv */
// Self-checking testbench for the pulse counter display driver unit.
`timescale 1ns / 100ps

module testbench;
    import pcdd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 64;
    localparam int HOLD_AT     = 600;
    localparam int N_DIRECTED  = 22;
    localparam int N_SETTINGS  = 5;

    // One row of the directed stimulus; res is used only when typed is set.
    typedef struct {
        op_t         op;
        logic [19:0] tgt;
        logic [20:0] dlt;
        bit          typed;
        result_t     res;
    } stim_row_t;

    // One register setting and the number of random items run under it.
    typedef struct {
        logic [15:0] pulse;
        logic [15:0] hold;
        logic [15:0] post;
        logic        dec;
        int          n_items;
    } setting_t;

    logic                   aclk;
    logic                   aresetn;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    // Mirror of the block's registers and sequencer.
    logic [15:0] pulse_ms_r;
    logic [15:0] hold_ms_r;
    logic [15:0] post_ms_r;
    logic        has_dec_r;
    logic [19:0] goal_r;
    logic [19:0] shown_r;
    phase_t      phase_r;
    logic [15:0] time_left_r;
    logic [2:0]  pulses_left_r;
    logic [2:0]  pulses_done_r;
    logic        going_down_r;

    result_t   pending_results[$];
    int        mismatches;
    int        results_seen;
    int        cycles;
    bit        steady_flow;
    stim_row_t directed_rows[N_DIRECTED];
    setting_t  settings[N_SETTINGS];

    pulse_counter_display_driver_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic result_t line_levels(input logic inc, input logic dec, input logic rst,
                                            input logic [19:0] shown, input logic [19:0] goal,
                                            input logic busy);
        result_t r;
        r.inc_line    = inc;
        r.dec_line    = dec;
        r.reset_line  = rst;
        r.shown_count = shown;
        r.goal_count  = goal;
        r.busy_res    = busy;
        return r;
    endfunction

    // Pick a reset sequence or a pulse burst once the count differs from the target.
    function automatic void choose_action();
        logic [19:0]     span;
        logic            down;
        longint unsigned lhs;
        longint unsigned rhs;
        if (goal_r == shown_r) begin
            phase_r = PH_IDLE;
            return;
        end
        down = goal_r < shown_r;
        span = down ? shown_r - goal_r : goal_r - shown_r;
        lhs  = 64'(goal_r) * 64'd2 * 64'(pulse_ms_r) + 64'd2 * 64'(hold_ms_r) + 64'(post_ms_r);
        rhs  = 64'(span) * 64'd2 * 64'(pulse_ms_r);
        if (lhs < rhs || (down && !has_dec_r)) begin
            shown_r     = '0;
            phase_r     = PH_RST_PRE;
            time_left_r = hold_ms_r;
            return;
        end
        going_down_r  = down;
        pulses_left_r = (span > 20'(BURST_LIMIT_DEF)) ? 3'(BURST_LIMIT_DEF) : span[2:0];
        pulses_done_r = '0;
        phase_r       = PH_P_HIGH;
        time_left_r   = pulse_ms_r;
    endfunction

    // One millisecond of sequencer time.
    function automatic void advance_ms();
        if (phase_r == PH_IDLE) begin
            choose_action();
            return;
        end
        if (time_left_r != 16'd0) time_left_r = time_left_r - 16'd1;
        if (time_left_r != 16'd0) return;
        case (phase_r)
            PH_RST_PRE: begin
                phase_r     = PH_RST_HIGH;
                time_left_r = hold_ms_r;
            end
            PH_RST_HIGH: begin
                phase_r     = PH_RST_POST;
                time_left_r = post_ms_r;
            end
            PH_P_HIGH: begin
                phase_r     = PH_P_LOW;
                time_left_r = pulse_ms_r;
            end
            PH_P_LOW: begin
                pulses_done_r = pulses_done_r + 3'd1;
                if (pulses_left_r != 3'd0) pulses_left_r = pulses_left_r - 3'd1;
                if (pulses_left_r != 3'd0) begin
                    phase_r     = PH_P_HIGH;
                    time_left_r = pulse_ms_r;
                end else begin
                    // The count is only moved once the whole burst is out.
                    if (going_down_r)
                        shown_r = (shown_r >= 20'(pulses_done_r)) ?
                                  shown_r - 20'(pulses_done_r) : '0;
                    else
                        shown_r = shown_r + 20'(pulses_done_r);
                    phase_r = PH_IDLE;
                    choose_action();
                end
            end
            default: begin
                phase_r = PH_IDLE;
                choose_action();
            end
        endcase
    endfunction

    // Apply one accepted item to the mirror and return the line levels that follow.
    function automatic result_t drive_levels_after(input item_t it);
        logic [20:0] raw;
        logic [21:0] mag;
        logic [21:0] sum;
        raw = it.delta;
        case (it.operation)
            OP_TICK: advance_ms();
            OP_SET:  goal_r = it.new_target;
            OP_ADD: begin
                if (raw[20]) begin
                    mag    = 22'h200000 - {1'b0, raw};
                    goal_r = ({2'b0, goal_r} >= mag) ? goal_r - mag[19:0] : '0;
                end else begin
                    sum    = {2'b0, goal_r} + {1'b0, raw};
                    goal_r = (sum > 22'hFFFFF) ? 20'hFFFFF : sum[19:0];
                end
            end
            default: ;
        endcase
        return line_levels(phase_r == PH_P_HIGH && !going_down_r,
                           phase_r == PH_P_HIGH && going_down_r,
                           phase_r == PH_RST_HIGH, shown_r, goal_r, phase_r != PH_IDLE);
    endfunction

    // Register write through the configuration port, mirrored in the model.
    task automatic write_register(input cfg_index_t idx, input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_PULSE_MS:      if (value != 16'd0) pulse_ms_r = value;
            CFG_RESET_HOLD_MS: if (value != 16'd0) hold_ms_r = value;
            CFG_POST_RESET_MS: if (value != 16'd0) post_ms_r = value;
            CFG_HAS_DECREMENT: has_dec_r = value[0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Offer one item after a random gap and record what it should produce.
    task automatic send_item(input item_t it, input bit typed, input result_t typed_res);
        int      gap;
        result_t predicted;
        gap = steady_flow ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'(it);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = drive_levels_after(it);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    // Stop offering and wait until every outstanding result has come back.
    task automatic drain_block();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Random request: mostly ticks, targets kept small with rare far jumps.
    function automatic item_t random_request();
        item_t it;
        int    pick;
        int    dv;
        pick         = $urandom_range(0, 99);
        it.new_target = 20'($urandom);
        it.delta      = 21'($urandom);
        if (pick < 70) begin
            it.operation = OP_TICK;
        end else if (pick < 80) begin
            it.operation = OP_SET;
            pick = $urandom_range(0, 99);
            if (pick < 80)      it.new_target = 20'($urandom_range(0, 40));
            else if (pick < 95) it.new_target = 20'($urandom_range(0, 400));
        end else if (pick < 93) begin
            it.operation = OP_ADD;
            if ($urandom_range(0, 9) != 0) dv = int'($urandom_range(0, 20)) - 10;
            else                           dv = int'($urandom_range(0, 2097150)) - 1048575;
            it.delta = dv[20:0];
        end else begin
            it.operation = OP_NOP;
        end
        return it;
    endfunction

    // Result side: random stalls, one long hold-off, and the scoreboard compare.
    initial begin
        int      stall;
        result_t got;
        result_t want;
        m_tready     <= 1'b0;
        results_seen = 0;
        mismatches   = 0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, 3);
            if (results_seen == HOLD_AT) stall = LONG_HOLD;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            got = result_t'(m_tdata[RESULT_W-1:0]);
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected: %h", got);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (got.inc_line !== want.inc_line) begin
                    $error("inc_line expected %0d actual %0d", want.inc_line, got.inc_line);
                    mismatches++;
                end
                if (got.dec_line !== want.dec_line) begin
                    $error("dec_line expected %0d actual %0d", want.dec_line, got.dec_line);
                    mismatches++;
                end
                if (got.reset_line !== want.reset_line) begin
                    $error("reset_line expected %0d actual %0d", want.reset_line,
                           got.reset_line);
                    mismatches++;
                end
                if (got.shown_count !== want.shown_count) begin
                    $error("shown_count expected %0d actual %0d", want.shown_count,
                           got.shown_count);
                    mismatches++;
                end
                if (got.goal_count !== want.goal_count) begin
                    $error("goal_count expected %0d actual %0d", want.goal_count,
                           got.goal_count);
                    mismatches++;
                end
                if (got.busy_res !== want.busy_res) begin
                    $error("busy_res expected %0d actual %0d", want.busy_res, got.busy_res);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Stimulus: reset, directed table at the default registers, then random phases.
    initial begin
        item_t   it;
        result_t none;
        none = '0;

        directed_rows = '{
            '{OP_NOP,  20'hFFFFF, 21'h1FFFFF, 1'b1,
              line_levels(1'b0, 1'b0, 1'b0, 20'd0, 20'd0, 1'b0)},
            '{OP_TICK, 20'hFFFFF, 21'h1FFFFF, 1'b1,
              line_levels(1'b0, 1'b0, 1'b0, 20'd0, 20'd0, 1'b0)},
            '{OP_SET,  20'd3,     21'h0,      1'b1,
              line_levels(1'b0, 1'b0, 1'b0, 20'd0, 20'd3, 1'b0)},
            '{OP_TICK, 20'h0,     21'h0,      1'b1,
              line_levels(1'b1, 1'b0, 1'b0, 20'd0, 20'd3, 1'b1)},
            '{OP_ADD,  20'h0,     21'd2,      1'b1,
              line_levels(1'b1, 1'b0, 1'b0, 20'd0, 20'd5, 1'b1)},
            '{OP_ADD,  20'h0,     21'h100001, 1'b1,
              line_levels(1'b1, 1'b0, 1'b0, 20'd0, 20'd0, 1'b1)},
            '{OP_ADD,  20'h0,     21'h0FFFFF, 1'b1,
              line_levels(1'b1, 1'b0, 1'b0, 20'd0, 20'hFFFFF, 1'b1)},
            '{OP_ADD,  20'h0,     21'd1,      1'b1,
              line_levels(1'b1, 1'b0, 1'b0, 20'd0, 20'hFFFFF, 1'b1)},
            '{OP_SET,  20'h0,     21'h1FFFFF, 1'b1,
              line_levels(1'b1, 1'b0, 1'b0, 20'd0, 20'd0, 1'b1)},
            '{OP_SET,  20'hFFFFF, 21'h0,      1'b1,
              line_levels(1'b1, 1'b0, 1'b0, 20'd0, 20'hFFFFF, 1'b1)},
            '{OP_NOP,  20'h0,     21'h0,      1'b1,
              line_levels(1'b1, 1'b0, 1'b0, 20'd0, 20'hFFFFF, 1'b1)},
            '{OP_SET,  20'd7,     21'h0,      1'b0, none},
            '{OP_TICK, 20'h0,     21'h0,      1'b0, none},
            '{OP_TICK, 20'h0,     21'h0,      1'b0, none},
            '{OP_TICK, 20'h0,     21'h0,      1'b0, none},
            '{OP_TICK, 20'h0,     21'h0,      1'b0, none},
            '{OP_TICK, 20'h0,     21'h0,      1'b0, none},
            '{OP_ADD,  20'h0,     21'h1FFFFD, 1'b0, none},
            '{OP_ADD,  20'h0,     21'h0,      1'b0, none},
            '{OP_TICK, 20'h0,     21'h0,      1'b0, none},
            '{OP_TICK, 20'h0,     21'h0,      1'b0, none},
            '{OP_TICK, 20'h0,     21'h0,      1'b0, none}
        };
        settings = '{
            '{16'd1,     16'd1,     16'd1,     1'b1, 500},
            '{16'd2,     16'd3,     16'd2,     1'b0, 400},
            '{16'd65535, 16'd65535, 16'd65535, 1'b1, 120},
            '{16'd3,     16'd1,     16'd5,     1'b1, 400},
            '{16'd1,     16'd2,     16'd1,     1'b0, 430}
        };

        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= CFG_PULSE_MS;
        cfg_wdata   <= '0;
        steady_flow = 1'b0;

        pulse_ms_r    = PULSE_MS_RST;
        hold_ms_r     = RESET_HOLD_MS_RST;
        post_ms_r     = POST_RESET_MS_RST;
        has_dec_r     = HAS_DEC_RST;
        goal_r        = '0;
        shown_r       = '0;
        phase_r       = PH_IDLE;
        time_left_r   = '0;
        pulses_left_r = '0;
        pulses_done_r = '0;
        going_down_r  = 1'b0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            it.operation  = directed_rows[i].op;
            it.new_target = directed_rows[i].tgt;
            it.delta      = directed_rows[i].dlt;
            send_item(it, directed_rows[i].typed, directed_rows[i].res);
        end
        drain_block();

        foreach (settings[p]) begin
            write_register(CFG_PULSE_MS, settings[p].pulse);
            write_register(CFG_RESET_HOLD_MS, settings[p].hold);
            write_register(CFG_POST_RESET_MS, settings[p].post);
            write_register(CFG_HAS_DECREMENT, {15'd0, settings[p].dec});
            // A zero write to a timing register must leave the old value in place.
            if (p == 1) write_register(CFG_POST_RESET_MS, 16'd0);
            if (p == 3) write_register(CFG_PULSE_MS, 16'd0);
            for (int n = 0; n < settings[p].n_items; n++) begin
                if (n % 100 == 0) steady_flow = ($urandom_range(0, 3) == 0);
                if (n == settings[p].n_items / 2) drain_block();
                send_item(random_request(), 1'b0, none);
            end
            drain_block();
        end

        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
